/* sv/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

/* sv/dll_pkg.sv */
// types, codes and helpers of the linked list manager
package dll_pkg;

  localparam int MODE_W     = 3;
  localparam int LIST_IN_W  = 2;
  localparam int NODE_IN_W  = 6;
  localparam int NODE_OUT_W = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR    = 3'd0,
    MODE_INS_TAIL = 3'd1,
    MODE_INS_HEAD = 3'd2,
    MODE_DELETE   = 3'd3,
    MODE_GET_HEAD = 3'd4,
    MODE_GET_TAIL = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_LINKED   = 2'd2,
    ST_UNLINKED = 2'd3
  } status_t;

  typedef struct packed {
    status_t                 status;
    logic [NODE_OUT_W-1:0]   node;
    logic                    empty;
  } res_t;

  function automatic res_t make_res(status_t s, logic [NODE_OUT_W-1:0] n, logic e);
    res_t r;
    r.status = s;
    r.node   = n;
    r.empty  = e;
    return r;
  endfunction

endpackage

/* sv/dll_ram.sv */
// generic simple dual port ram with registered read
module dll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/dll_ctrl.sv */
// sequencer over the node and list memories
module dll_ctrl #(
  parameter int NODE_COUNT = 64,
  parameter int LIST_COUNT = 4,
  parameter int NW = $clog2(NODE_COUNT),
  parameter int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  dll_pkg::mode_t  cmd_mode,
  input  logic [LW-1:0]   cmd_list,
  input  logic [NW-1:0]   cmd_node,
  output logic            busy,
  output dll_pkg::res_t   res,
  output logic            res_valid
);
  import dll_pkg::*;

  localparam int PW = $clog2(NODE_COUNT + 1);
  localparam logic [PW-1:0] NIL = PW'(NODE_COUNT);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODE_COUNT - 1);

  typedef struct packed {
    logic          linked;
    logic [LW-1:0] owner;
    logic [PW-1:0] prev;
    logic [PW-1:0] nxt;
  } node_t;

  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
  } lent_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_EXEC, S_LINK, S_DEL_P, S_DEL_Q, S_SWEEP
  } state_t;

  state_t          state_r, state_nxt;
  mode_t           mode_r, mode_nxt;
  logic [LW-1:0]   list_r, list_nxt;
  logic [NW-1:0]   node_r, node_nxt;
  logic [PW-1:0]   p_r, p_nxt;
  logic [PW-1:0]   q_r, q_nxt;
  logic [LW-1:0]   o_r, o_nxt;
  logic [PW-1:0]   nb_r, nb_nxt;
  logic            emp_r, emp_nxt;
  logic [PW-1:0]   cnt_r, cnt_nxt;
  logic [NW-1:0]   sw_addr_r, sw_addr_nxt;
  logic            sw_vld_r, sw_vld_nxt;
  logic [LIST_COUNT-1:0] lvld_r, lvld_nxt;
  res_t            res_r, res_nxt;
  logic            res_vld_r, res_vld_nxt;

  logic            nm_we;
  logic [NW-1:0]   nm_waddr, nm_raddr;
  node_t           nm_wdata, nm_rd;
  logic            lm_we;
  logic [LW-1:0]   lm_waddr, lm_raddr;
  lent_t           lm_wdata, lm_rd;

  logic [PW-1:0]   cur_head, cur_tail, get_ptr;
  logic [PW-1:0]   own_head, own_tail, new_head, new_tail;
  logic [PW-1:0]   node_ptr;

  dll_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_COUNT), .AW(NW)) u_node_ram (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .raddr (nm_raddr),
    .rdata (nm_rd)
  );

  dll_ram #(.WIDTH($bits(lent_t)), .DEPTH(LIST_COUNT), .AW(LW)) u_list_ram (
    .clk   (clk),
    .we    (lm_we),
    .waddr (lm_waddr),
    .wdata (lm_wdata),
    .raddr (lm_raddr),
    .rdata (lm_rd)
  );

  assign node_ptr = PW'(node_r);
  assign cur_head = lvld_r[list_r] ? lm_rd.head : NIL;
  assign cur_tail = lvld_r[list_r] ? lm_rd.tail : NIL;
  assign get_ptr  = (mode_r == MODE_GET_HEAD) ? cur_head : cur_tail;
  assign own_head = lvld_r[o_r] ? lm_rd.head : NIL;
  assign own_tail = lvld_r[o_r] ? lm_rd.tail : NIL;
  assign new_head = (p_r == NIL) ? q_r : own_head;
  assign new_tail = (q_r == NIL) ? p_r : own_tail;

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    list_nxt    = list_r;
    node_nxt    = node_r;
    p_nxt       = p_r;
    q_nxt       = q_r;
    o_nxt       = o_r;
    nb_nxt      = nb_r;
    emp_nxt     = emp_r;
    cnt_nxt     = cnt_r;
    sw_addr_nxt = sw_addr_r;
    sw_vld_nxt  = sw_vld_r;
    lvld_nxt    = lvld_r;
    res_nxt     = res_r;
    res_vld_nxt = 1'b0;
    nm_we       = 1'b0;
    nm_waddr    = node_r;
    nm_wdata    = nm_rd;
    nm_raddr    = node_r;
    lm_we       = 1'b0;
    lm_waddr    = list_r;
    lm_wdata    = lm_rd;
    lm_raddr    = list_r;

    unique case (state_r)
      S_INIT: begin
        nm_we    = 1'b1;
        nm_waddr = cnt_r[NW-1:0];
        nm_wdata = '0;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r[NW-1:0] == LAST_NODE) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        nm_raddr = cmd_node;
        lm_raddr = cmd_list;
        if (start) begin
          mode_nxt  = cmd_mode;
          list_nxt  = cmd_list;
          node_nxt  = cmd_node;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (mode_r)
          MODE_CLEAR: begin
            lvld_nxt[list_r] = 1'b0;
            cnt_nxt          = '0;
            sw_vld_nxt       = 1'b0;
            state_nxt        = S_SWEEP;
          end
          MODE_INS_TAIL, MODE_INS_HEAD: begin
            if (nm_rd.linked) begin
              res_nxt     = make_res(ST_LINKED, '0, cur_head == NIL);
              res_vld_nxt = 1'b1;
              state_nxt   = S_IDLE;
            end else begin
              nm_we           = 1'b1;
              nm_wdata.linked = 1'b1;
              nm_wdata.owner  = list_r;
              lm_we           = 1'b1;
              lvld_nxt[list_r] = 1'b1;
              if (cur_head == NIL) begin
                nm_wdata.prev = NIL;
                nm_wdata.nxt  = NIL;
                lm_wdata.head = node_ptr;
                lm_wdata.tail = node_ptr;
                res_nxt       = make_res(ST_OK, '0, 1'b0);
                res_vld_nxt   = 1'b1;
                state_nxt     = S_IDLE;
              end else if (mode_r == MODE_INS_TAIL) begin
                nm_wdata.prev = cur_tail;
                nm_wdata.nxt  = NIL;
                lm_wdata.head = cur_head;
                lm_wdata.tail = node_ptr;
                nm_raddr      = cur_tail[NW-1:0];
                nb_nxt        = cur_tail;
                state_nxt     = S_LINK;
              end else begin
                nm_wdata.prev = NIL;
                nm_wdata.nxt  = cur_head;
                lm_wdata.head = node_ptr;
                lm_wdata.tail = cur_tail;
                nm_raddr      = cur_head[NW-1:0];
                nb_nxt        = cur_head;
                state_nxt     = S_LINK;
              end
            end
          end
          MODE_DELETE: begin
            if (!nm_rd.linked) begin
              res_nxt     = make_res(ST_UNLINKED, '0, 1'b0);
              res_vld_nxt = 1'b1;
              state_nxt   = S_IDLE;
            end else begin
              nm_we           = 1'b1;
              nm_wdata.linked = 1'b0;
              p_nxt           = nm_rd.prev;
              q_nxt           = nm_rd.nxt;
              o_nxt           = nm_rd.owner;
              nm_raddr        = nm_rd.prev[NW-1:0];
              lm_raddr        = nm_rd.owner;
              state_nxt       = S_DEL_P;
            end
          end
          MODE_GET_HEAD, MODE_GET_TAIL: begin
            if (get_ptr == NIL) begin
              res_nxt = make_res(ST_EMPTY, '0, 1'b1);
            end else begin
              res_nxt = make_res(ST_OK, NODE_OUT_W'(get_ptr), 1'b0);
            end
            res_vld_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end
          default: begin
            res_nxt     = make_res(ST_OK, '0, cur_head == NIL);
            res_vld_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end
        endcase
      end
      S_LINK: begin
        nm_we    = 1'b1;
        nm_waddr = nb_r[NW-1:0];
        if (mode_r == MODE_INS_TAIL) begin
          nm_wdata.nxt = node_ptr;
        end else begin
          nm_wdata.prev = node_ptr;
        end
        res_nxt     = make_res(ST_OK, '0, 1'b0);
        res_vld_nxt = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_DEL_P: begin
        if (p_r != NIL) begin
          nm_we        = 1'b1;
          nm_waddr     = p_r[NW-1:0];
          nm_wdata.nxt = q_r;
        end
        nm_raddr = q_r[NW-1:0];
        if ((p_r == NIL) || (q_r == NIL)) begin
          lm_we         = 1'b1;
          lm_waddr      = o_r;
          lm_wdata.head = new_head;
          lm_wdata.tail = new_tail;
        end
        emp_nxt   = (new_head == NIL);
        state_nxt = S_DEL_Q;
      end
      S_DEL_Q: begin
        if (q_r != NIL) begin
          nm_we         = 1'b1;
          nm_waddr      = q_r[NW-1:0];
          nm_wdata.prev = p_r;
        end
        res_nxt     = make_res(ST_OK, '0, emp_r);
        res_vld_nxt = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SWEEP: begin
        nm_raddr = cnt_r[NW-1:0];
        if (sw_vld_r && nm_rd.linked && (nm_rd.owner == list_r)) begin
          nm_we           = 1'b1;
          nm_waddr        = sw_addr_r;
          nm_wdata.linked = 1'b0;
        end
        cnt_nxt     = cnt_r + 1'b1;
        sw_addr_nxt = cnt_r[NW-1:0];
        sw_vld_nxt  = 1'b1;
        if (sw_vld_r && (sw_addr_r == LAST_NODE)) begin
          res_nxt     = make_res(ST_OK, '0, 1'b1);
          res_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      cnt_r     <= '0;
      sw_vld_r  <= 1'b0;
      lvld_r    <= '0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      sw_vld_r  <= sw_vld_nxt;
      lvld_r    <= lvld_nxt;
      res_vld_r <= res_vld_nxt;
    end
    mode_r    <= mode_nxt;
    list_r    <= list_nxt;
    node_r    <= node_nxt;
    p_r       <= p_nxt;
    q_r       <= q_nxt;
    o_r       <= o_nxt;
    nb_r      <= nb_nxt;
    emp_r     <= emp_nxt;
    sw_addr_r <= sw_addr_nxt;
    res_r     <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res       = res_r;
  assign res_valid = res_vld_r;

endmodule

/* sv/doubly_linked_list_manager.sv */
// top level of the doubly linked list manager
//
//  port group   direction  handshake                 word
//  in_*         in         start high, busy low      mode, list, node
//  out_*        out        out_valid for one cycle   status, node, empty
//
// after reset the node memory is swept clear with busy high
// get, misc and failed ops: accept, then exec registers the result
// insert: exec, then link if the list was not empty; delete: exec, del_p, del_q (node, prev neighbor, next neighbor)
// clear: exec, then a sweep that reads one node memory entry per cycle and unlinks the nodes of that list
// the node memory ports set these steps; results cannot be stalled
module doubly_linked_list_manager #(
  parameter int NODE_COUNT = 64,
  parameter int LIST_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [1:0]  in_list_id,
  input  logic [5:0]  in_node_index,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [5:0]  out_result_node,
  output logic        out_list_empty
);
  import dll_pkg::*;

  `include "assert_macros.svh"

  localparam int NW = $clog2(NODE_COUNT);
  localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;

  logic [LW-1:0] cmd_list;
  logic [NW-1:0] cmd_node;
  res_t          res;

  function automatic logic [LW-1:0] list_mod(logic [LIST_IN_W-1:0] v);
    int r;
    r = int'(v);
    for (int k = LIST_IN_W - 1; k >= 0; k--) begin
      if (r >= (LIST_COUNT << k)) begin
        r = r - (LIST_COUNT << k);
      end
    end
    return LW'(r);
  endfunction

  function automatic logic [NW-1:0] node_mod(logic [NODE_IN_W-1:0] v);
    int r;
    r = int'(v);
    for (int k = NODE_IN_W - 1; k >= 0; k--) begin
      if (r >= (NODE_COUNT << k)) begin
        r = r - (NODE_COUNT << k);
      end
    end
    return NW'(r);
  endfunction

  assign cmd_list = list_mod(in_list_id);
  assign cmd_node = node_mod(in_node_index);

  dll_ctrl #(.NODE_COUNT(NODE_COUNT), .LIST_COUNT(LIST_COUNT), .NW(NW), .LW(LW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd_mode  (mode_t'(in_mode)),
    .cmd_list  (cmd_list),
    .cmd_node  (cmd_node),
    .busy      (busy),
    .res       (res),
    .res_valid (out_valid)
  );

  assign out_status      = res.status;
  assign out_result_node = res.node;
  assign out_list_empty  = res.empty;

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_IMPL(a_result_idle, clk, rst_n, out_valid, !busy)
  `ASSERT_NEXT(a_result_single, clk, rst_n, out_valid, !out_valid)

endmodule

/* verif/dll_list_checker.sv */
// checker that predicts and compares every result word of the linked list manager
`timescale 1ns / 1ps

module dll_list_checker #(
  parameter int NODE_COUNT = 64,
  parameter int LIST_COUNT = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] in_mode,
  input  logic [1:0] in_list_id,
  input  logic [5:0] in_node_index,
  input  logic       out_valid,
  input  logic [1:0] out_status,
  input  logic [5:0] out_result_node,
  input  logic       out_list_empty,
  output int         fail_count,
  output int         replies_owed
);
  import dll_pkg::*;

  localparam logic [6:0] NIL = 7'(NODE_COUNT);

  logic [6:0] head_of   [LIST_COUNT];
  logic [6:0] tail_of   [LIST_COUNT];
  logic [6:0] prev_of   [NODE_COUNT];
  logic [6:0] next_of   [NODE_COUNT];
  logic [1:0] owner_of  [NODE_COUNT];
  logic       is_linked [NODE_COUNT];

  res_t expected_replies[$];

  // applies one list operation to the shadow lists and returns the reply it should give
  function automatic res_t apply_list_op(logic [2:0] op, logic [1:0] lst, logic [5:0] nd);
    logic [6:0] p;
    logic [6:0] q;
    logic [6:0] r;
    logic [1:0] o;
    res_t res;
    res.status = ST_OK;
    res.node   = '0;
    res.empty  = 1'b0;
    case (op)
      MODE_CLEAR: begin
        head_of[lst] = NIL;
        tail_of[lst] = NIL;
        for (int i = 0; i < NODE_COUNT; i++)
          if (is_linked[i] && owner_of[i] == lst) is_linked[i] = 1'b0;
        res.empty = 1'b1;
      end
      MODE_INS_TAIL, MODE_INS_HEAD: begin
        if (is_linked[nd]) begin
          res.status = ST_LINKED;
          res.empty  = (head_of[lst] == NIL);
        end else begin
          if (head_of[lst] == NIL) begin
            head_of[lst] = 7'(nd);
            tail_of[lst] = 7'(nd);
            prev_of[nd]  = NIL;
            next_of[nd]  = NIL;
          end else if (op == MODE_INS_TAIL) begin
            next_of[tail_of[lst]] = 7'(nd);
            prev_of[nd]           = tail_of[lst];
            next_of[nd]           = NIL;
            tail_of[lst]          = 7'(nd);
          end else begin
            prev_of[head_of[lst]] = 7'(nd);
            prev_of[nd]           = NIL;
            next_of[nd]           = head_of[lst];
            head_of[lst]          = 7'(nd);
          end
          owner_of[nd]  = lst;
          is_linked[nd] = 1'b1;
        end
      end
      MODE_DELETE: begin
        if (!is_linked[nd]) begin
          res.status = ST_UNLINKED;
        end else begin
          p = prev_of[nd];
          q = next_of[nd];
          o = owner_of[nd];
          if (p >= NIL) head_of[o] = q;
          else next_of[p[5:0]] = q;
          if (q >= NIL) tail_of[o] = p;
          else prev_of[q[5:0]] = p;
          is_linked[nd] = 1'b0;
          res.empty = (head_of[o] == NIL);
        end
      end
      MODE_GET_HEAD, MODE_GET_TAIL: begin
        r = (op == MODE_GET_HEAD) ? head_of[lst] : tail_of[lst];
        if (r == NIL) begin
          res.status = ST_EMPTY;
          res.empty  = 1'b1;
        end else begin
          res.node = r[5:0];
        end
      end
      default: res.empty = (head_of[lst] == NIL);
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    res_t want;
    int   errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < LIST_COUNT; i++) begin
        head_of[i] = NIL;
        tail_of[i] = NIL;
      end
      for (int i = 0; i < NODE_COUNT; i++) is_linked[i] = 1'b0;
      expected_replies.delete();
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected word status %0d node %0d empty %0d", $time,
                   out_status, out_result_node, out_list_empty);
          errs++;
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            errs++;
          end
          if (out_result_node !== want.node) begin
            $display("%0t: result_node expected %0d actual %0d", $time, want.node,
                     out_result_node);
            errs++;
          end
          if (out_list_empty !== want.empty) begin
            $display("%0t: list_empty expected %0d actual %0d", $time, want.empty,
                     out_list_empty);
            errs++;
          end
        end
      end
      if (start && !busy)
        expected_replies.push_back(apply_list_op(in_mode, in_list_id, in_node_index));
      fail_count <= fail_count + errs;
    end
    replies_owed <= expected_replies.size();
  end

endmodule

/* verif/tb_doubly_linked_list_manager.sv */
// testbench top of the linked list manager: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module tb_doubly_linked_list_manager;
  import dll_pkg::*;

  localparam int NODE_COUNT = 64;
  localparam int LIST_COUNT = 4;
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam int RANDOM_OPS = 1000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_mode = '0;
  logic [1:0] in_list_id = '0;
  logic [5:0] in_node_index = '0;
  logic       out_valid;
  logic [1:0] out_status;
  logic [5:0] out_result_node;
  logic       out_list_empty;
  int         fail_count;
  int         replies_owed;

  // stimulus-side view of which nodes sit in a list, used to steer node choice
  bit         node_taken [NODE_COUNT];
  logic [1:0] node_list  [NODE_COUNT];

  always #6 clk = ~clk;

  doubly_linked_list_manager #(.NODE_COUNT(NODE_COUNT), .LIST_COUNT(LIST_COUNT)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_list_id(in_list_id), .in_node_index(in_node_index),
    .out_valid(out_valid), .out_status(out_status), .out_result_node(out_result_node),
    .out_list_empty(out_list_empty)
  );

  dll_list_checker #(.NODE_COUNT(NODE_COUNT), .LIST_COUNT(LIST_COUNT)) checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_list_id(in_list_id), .in_node_index(in_node_index),
    .out_valid(out_valid), .out_status(out_status), .out_result_node(out_result_node),
    .out_list_empty(out_list_empty), .fail_count(fail_count), .replies_owed(replies_owed)
  );

  task automatic send_word(logic [2:0] op, logic [1:0] lst, logic [5:0] nd);
    start         <= 1'b1;
    in_mode       <= op;
    in_list_id    <= lst;
    in_node_index <= nd;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (op)
      MODE_CLEAR:
        for (int i = 0; i < NODE_COUNT; i++)
          if (node_taken[i] && node_list[i] == lst) node_taken[i] = 1'b0;
      MODE_INS_TAIL, MODE_INS_HEAD:
        if (!node_taken[nd]) begin
          node_taken[nd] = 1'b1;
          node_list[nd]  = lst;
        end
      MODE_DELETE: node_taken[nd] = 1'b0;
      default: ;
    endcase
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 14)) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (replies_owed != 0);
  endtask

  function automatic logic [5:0] pick_node(bit want_taken);
    logic [5:0] nd;
    nd = 6'($urandom_range(0, NODE_COUNT - 1));
    for (int t = 0; t < 12 && node_taken[nd] != want_taken; t++)
      nd = 6'($urandom_range(0, NODE_COUNT - 1));
    return nd;
  endfunction

  initial begin
    int roll;
    logic [1:0] lst;
    for (int i = 0; i < NODE_COUNT; i++) node_taken[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty lists, bad delete, insert both ends, duplicate insert, unlink middle, head and sole node
    send_word(MODE_GET_HEAD, 2'd0, 6'd0);
    send_word(MODE_GET_TAIL, 2'd3, 6'd0);
    send_word(MODE_DELETE, 2'd1, 6'd63);
    send_word(MODE_INS_TAIL, 2'd0, 6'd0);
    send_word(MODE_INS_TAIL, 2'd0, 6'd63);
    send_word(MODE_INS_HEAD, 2'd0, 6'd5);
    send_word(MODE_INS_TAIL, 2'd3, 6'd63);
    send_word(MODE_INS_HEAD, 2'd0, 6'd5);
    send_word(MODE_GET_HEAD, 2'd0, 6'd0);
    send_word(MODE_GET_TAIL, 2'd0, 6'd0);
    send_word(MODE_DELETE, 2'd2, 6'd0);
    send_word(MODE_DELETE, 2'd0, 6'd5);
    send_word(MODE_GET_HEAD, 2'd0, 6'd0);
    send_word(MODE_DELETE, 2'd0, 6'd63);
    send_word(MODE_GET_TAIL, 2'd0, 6'd0);
    send_word(MODE_INS_HEAD, 2'd3, 6'd10);
    send_word(MODE_INS_TAIL, 2'd3, 6'd42);
    send_word(MODE_SPARE_A, 2'd3, 6'd21);
    send_word(MODE_SPARE_B, 2'd2, 6'd21);
    send_word(MODE_CLEAR, 2'd3, 6'd63);
    send_word(MODE_GET_HEAD, 2'd3, 6'd0);
    send_word(MODE_INS_TAIL, 2'd2, 6'd10);
    send_word(MODE_DELETE, 2'd2, 6'd42);
    send_word(MODE_CLEAR, 2'd1, 6'd0);
    wait_drained();

    for (int k = 0; k < RANDOM_OPS; k++) begin
      roll = $urandom_range(0, 99);
      lst  = 2'($urandom_range(0, LIST_COUNT - 1));
      if (roll < 35)
        send_word(roll[0] ? MODE_INS_TAIL : MODE_INS_HEAD, lst,
                  pick_node($urandom_range(0, 99) < 12));
      else if (roll < 60)
        send_word(MODE_DELETE, lst, pick_node($urandom_range(0, 99) < 88));
      else if (roll < 88)
        send_word(roll[0] ? MODE_GET_HEAD : MODE_GET_TAIL, lst, 6'($urandom));
      else if (roll < 93)
        send_word(MODE_CLEAR, lst, 6'($urandom));
      else if (roll < 96)
        send_word(roll[0] ? MODE_SPARE_A : MODE_SPARE_B, lst, 6'($urandom));
      else
        send_word(3'($urandom_range(0, 7)), lst, 6'($urandom));
      if (k < RANDOM_OPS - 150 && (k / 40) % 2 == 0 && $urandom_range(0, 3) == 0)
        idle_burst();
      if (k % 250 == 125) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && replies_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/dll_pkg.sv
sv/dll_ram.sv
sv/dll_ctrl.sv
sv/doubly_linked_list_manager.sv
verif/dll_list_checker.sv
verif/tb_doubly_linked_list_manager.sv
